### rtl/lzssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS decoder package
// Shared constants and types of the LZSS stream decoder.
// ----------------------------------------------------------------------------
package lzssd_pkg;

    // Window geometry.
    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int CFG_W            = 12;

    // Reset value of the stream start position.
    localparam logic [CFG_W-1:0] START_RESET = 12'h0FEE;

    // Token coding.
    localparam logic [4:0] MIN_MATCH       = 5'd3;
    localparam logic [3:0] TOKENS_PER_FLAG = 4'd8;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY
    } state_t;

endpackage

### rtl/lzssd_window_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS decoder window memory
// Single-port-write, single-port-read synchronous RAM with a registered read.
// A read of the entry being written in the same cycle returns the new byte.
// ----------------------------------------------------------------------------
module lzssd_window_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, write-first on an address collision.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/lzssd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS decoder controller
// Token parser, window clearing pass, reference copy sequencer and the
// output register of the decoded byte stream.
// ----------------------------------------------------------------------------
module lzssd_ctrl #(
    parameter int DEPTH = lzssd_pkg::WINDOW_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration
    input  logic                       cfg_wr_en,
    input  logic [lzssd_pkg::CFG_W-1:0] cfg_wr_data,
    // Compressed input
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_byte,
    input  logic                       s_new_stream,
    // Decoded output
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_byte,
    output logic                       m_last,
    // Window memory
    output logic                       ram_wr_en,
    output logic [AW-1:0]              ram_wr_addr,
    output logic [7:0]                 ram_wr_data,
    output logic                       ram_rd_en,
    output logic [AW-1:0]              ram_rd_addr,
    input  logic [7:0]                 ram_rd_data
);

    import lzssd_pkg::*;

    state_t           state_reg,     state_next;
    logic [AW-1:0]    clr_addr_reg,  clr_addr_next;
    logic [CFG_W-1:0] start_reg,     start_next;
    logic [AW-1:0]    wp_reg,        wp_next;
    logic [7:0]       flag_reg,      flag_next;
    logic [3:0]       tokens_reg,    tokens_next;
    logic             phase_reg,     phase_next;
    logic [7:0]       offlo_reg,     offlo_next;
    logic [AW-1:0]    src_reg,       src_next;
    logic [4:0]       remain_reg,    remain_next;
    logic             pend_reg,      pend_next;
    logic             pend_last_reg, pend_last_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg,  out_byte_next;
    logic             out_last_reg,  out_last_next;

    logic             out_free;

    // State registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            start_reg     <= START_RESET;
            wp_reg        <= AW'(START_RESET);
            flag_reg      <= '0;
            tokens_reg    <= '0;
            phase_reg     <= 1'b0;
            offlo_reg     <= '0;
            remain_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            start_reg     <= start_next;
            wp_reg        <= wp_next;
            flag_reg      <= flag_next;
            tokens_reg    <= tokens_next;
            phase_reg     <= phase_next;
            offlo_reg     <= offlo_next;
            remain_reg    <= remain_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        src_reg       <= src_next;
        pend_last_reg <= pend_last_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign out_free = !out_valid_reg || m_tready;

    // Next state, memory accesses and handshakes.
    always_comb begin
        logic [3:0]    tok;
        logic          ph;
        logic [AW-1:0] wp;

        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        start_next     = start_reg;
        wp_next        = wp_reg;
        flag_next      = flag_reg;
        tokens_next    = tokens_reg;
        phase_next     = phase_reg;
        offlo_next     = offlo_reg;
        src_next       = src_reg;
        remain_next    = remain_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = wp_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = src_reg;
        s_tready    = 1'b0;

        tok = tokens_reg;
        ph  = phase_reg;
        wp  = wp_reg;

        // The start position may change at any time; it is used at the next restart.
        if (cfg_wr_en) begin
            start_next = cfg_wr_data;
        end

        // The output register empties when the downstream side takes it.
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                // Zero the window, one entry per cycle.
                ram_wr_en     = 1'b1;
                ram_wr_addr   = clr_addr_reg;
                ram_wr_data   = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                s_tready = out_free;
                if (s_tvalid && out_free) begin
                    // A new stream reloads the pointer and expects a flag byte.
                    if (s_new_stream) begin
                        wp  = AW'(start_reg);
                        tok = '0;
                        ph  = 1'b0;
                    end
                    wp_next     = wp;
                    tokens_next = tok;
                    phase_next  = ph;

                    if (tok == '0) begin
                        flag_next   = s_byte;
                        tokens_next = TOKENS_PER_FLAG;
                        phase_next  = 1'b0;
                    end else if (!ph) begin
                        if (flag_reg[0]) begin
                            // Literal: store and emit it at once.
                            ram_wr_en      = 1'b1;
                            ram_wr_addr    = wp;
                            ram_wr_data    = s_byte;
                            wp_next        = wp + 1'b1;
                            out_valid_next = 1'b1;
                            out_byte_next  = s_byte;
                            out_last_next  = 1'b1;
                            flag_next      = flag_reg >> 1;
                            tokens_next    = tok - 1'b1;
                            phase_next     = 1'b0;
                        end else begin
                            // First byte of a reference holds the low offset.
                            offlo_next = s_byte;
                            phase_next = 1'b1;
                        end
                    end else begin
                        // Second byte of a reference starts the copy.
                        src_next    = AW'({s_byte[7:4], offlo_reg});
                        remain_next = {1'b0, s_byte[3:0]} + MIN_MATCH;
                        pend_next   = 1'b0;
                        state_next  = ST_COPY;
                        flag_next   = flag_reg >> 1;
                        tokens_next = tok - 1'b1;
                        phase_next  = 1'b0;
                    end
                end
            end

            ST_COPY: begin
                // Retire the pending fetched byte into the window and the output.
                if (pend_reg && out_free) begin
                    ram_wr_en      = 1'b1;
                    ram_wr_addr    = wp_reg;
                    ram_wr_data    = ram_rd_data;
                    wp_next        = wp_reg + 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rd_data;
                    out_last_next  = pend_last_reg;
                    pend_next      = 1'b0;
                end
                // Fetch the next source byte once the pending one can move on.
                if ((remain_reg != '0) && (!pend_reg || out_free)) begin
                    ram_rd_en      = 1'b1;
                    ram_rd_addr    = src_reg;
                    src_next       = src_reg + 1'b1;
                    remain_next    = remain_reg - 1'b1;
                    pend_next      = 1'b1;
                    pend_last_next = (remain_reg == 5'd1);
                end
                if ((remain_reg == '0) && (!pend_reg || out_free)) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_byte   = out_byte_reg;
    assign m_last   = out_last_reg;

endmodule

### rtl/lzss_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS stream decoder
// Decodes an LZSS byte stream through a ring window held in block RAM.
// A literal appears at the output in the cycle after it is taken. A
// reference keeps the input closed until its copy is done, one byte per
// cycle while the output is not stalled, paced by the single read port
// of the window RAM (read, then write back). After reset the window is
// zeroed in a clearing pass with no input taken.
// ----------------------------------------------------------------------------
module lzss_stream_decoder #(
    parameter int WINDOW_DEPTH = lzssd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration: start_position
    input  logic                        cfg_wr_en,
    input  logic [lzssd_pkg::CFG_W-1:0] cfg_wr_data,
    // Compressed input
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] in_byte
    input  logic                        s_tuser,   // [0] new_stream
    // Decoded output
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [7:0] out_byte
    output logic                        m_tlast    // last_of_run
);

    import lzssd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    // Parser, copy sequencer and output register.
    lzssd_ctrl #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_byte       (s_tdata),
        .s_new_stream (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_byte       (m_tdata),
        .m_last       (m_tlast),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    // Ring window.
    lzssd_window_ram #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

### rtl/lzssd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS decoder port checker
// Concurrent assertions on the ports of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lzssd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A request on the output is not withdrawn while it waits.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output request withdrawn while stalled");

    // Reset starts the clearing pass, which keeps the input closed.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input open right after reset");

    // While a reference is still being copied the input stays closed.
    a_no_input_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open in the middle of a copy");

    // Within a copy the next byte follows straight after a taken one.
    a_run_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a copied run");

endmodule

bind lzss_stream_decoder lzssd_checker u_lzssd_checker (.*);

### sim/lzss_stream_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS stream decoder testbench
// Feeds compressed byte requests through the slave stream and checks every
// decoded byte and its run marker against a local model of the decoder, which
// keeps its own copy of the ring window, the token parser and the start
// position. A directed stream comes first, then random streams under several
// start positions, with random idle bursts on both streams and one long
// output stall.
// ----------------------------------------------------------------------------
module lzss_stream_decoder_test;

    import lzssd_pkg::*;

    localparam int WIN_DEPTH      = WINDOW_DEPTH_DEF;
    localparam int PHASE_ITEMS    = 36;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_stream;
    } stream_request_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } decoded_byte_t;

    // Block ports; the inputs are driven to known values from time zero.
    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata     = 8'h00;   // [7:0] in_byte
    logic             s_tuser     = 1'b0;    // [0] new_stream
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [7:0]       m_tdata;               // [7:0] out_byte
    logic             m_tlast;               // last_of_run

    // Request and result queues.
    stream_request_t pending_requests[$];
    decoded_byte_t   expected_bytes[$];
    int              mismatches;

    // Decoder model state.
    logic [7:0]       hist [WIN_DEPTH];
    logic [11:0]      wr_ptr      = START_RESET;
    logic [11:0]      start_pos   = START_RESET;
    logic [7:0]       flag_bits   = 8'h00;
    logic [3:0]       tokens_left = 4'd0;
    logic             ref_pending = 1'b0;
    logic [7:0]       offset_low  = 8'h00;

    // Stream generator state.
    logic [11:0]      gen_ptr     = START_RESET;
    logic [11:0]      gen_start   = START_RESET;
    bit               gen_broken;

    // Flow control settings.
    bit               in_taken;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               send_gap;
    int               recv_gap;
    int               hold_left;
    bit               long_hold_go;
    bit               long_hold_used;

    lzss_stream_decoder u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Model: write one decoded byte into the window and expect it out.
    function automatic void store_byte(input logic [7:0] value, input logic last);
        decoded_byte_t res;
        res.out_byte    = value;
        res.last_of_run = last;
        hist[wr_ptr]    = value;
        wr_ptr          = wr_ptr + 12'd1;
        expected_bytes.push_back(res);
    endfunction

    function automatic void finish_token();
        flag_bits   = flag_bits >> 1;
        tokens_left = tokens_left - 4'd1;
        ref_pending = 1'b0;
    endfunction

    // Model: decode one accepted request.
    function automatic void decode_request(input logic [7:0] in_byte,
                                           input logic new_stream);
        logic [11:0] src;
        logic [4:0]  run_len;
        int          i;
        if (new_stream) begin
            wr_ptr      = start_pos;
            tokens_left = 4'd0;
            ref_pending = 1'b0;
        end
        if (tokens_left == 4'd0) begin
            flag_bits   = in_byte;
            tokens_left = TOKENS_PER_FLAG;
            ref_pending = 1'b0;
        end else if (!ref_pending) begin
            if (flag_bits[0]) begin
                store_byte(in_byte, 1'b1);
                finish_token();
            end else begin
                offset_low  = in_byte;
                ref_pending = 1'b1;
            end
        end else begin
            // Copy byte by byte so that an overlapping source repeats itself.
            src     = {in_byte[7:4], offset_low};
            run_len = {1'b0, in_byte[3:0]} + MIN_MATCH;
            for (i = 0; i < int'(run_len); i++) begin
                store_byte(hist[src + 12'(i)], i == int'(run_len) - 1);
            end
            finish_token();
        end
    endfunction

    function automatic void push_request(input logic [7:0] value, input logic restart);
        stream_request_t req;
        req.in_byte    = value;
        req.new_stream = restart;
        pending_requests.push_back(req);
    endfunction

    // Queue one flag byte and its tokens; now and then the stream is cut short.
    task automatic queue_stream(input bit restart);
        logic [7:0]  flags;
        logic [11:0] offs;
        logic [3:0]  len_code;
        int          cut_at;
        int          t;
        flags  = 8'($urandom_range(255, 0));
        cut_at = ($urandom_range(9, 0) == 0) ? $urandom_range(7, 0) : 8;
        if (restart) begin
            gen_ptr = gen_start;
        end
        push_request(flags, restart);
        for (t = 0; t < cut_at; t++) begin
            if (flags[t]) begin
                push_request(8'($urandom_range(255, 0)), 1'b0);
                gen_ptr = gen_ptr + 12'd1;
            end else begin
                // Recent offsets give overlapping copies of real data.
                if ($urandom_range(1, 0) == 1) begin
                    offs = gen_ptr - 12'($urandom_range(20, 1));
                end else begin
                    offs = 12'($urandom_range(4095, 0));
                end
                len_code = 4'($urandom_range(15, 0));
                push_request(offs[7:0], 1'b0);
                push_request({offs[11:8], len_code}, 1'b0);
                gen_ptr = gen_ptr + 12'(len_code) + 12'd3;
            end
        end
        gen_broken = (cut_at != 8);
        if (gen_broken) begin
            push_request(8'($urandom_range(255, 0)), 1'b0);
        end
    endtask

    // Random streams with a little noise in between.
    task automatic queue_random_phase(input int count);
        int target;
        target = pending_requests.size() + count;
        while (pending_requests.size() < target) begin
            if ($urandom_range(99, 0) < 8) begin
                push_request(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
                gen_broken = 1'b1;
            end else begin
                queue_stream(gen_broken || ($urandom_range(3, 0) == 0));
            end
        end
    endtask

    // Wait until every request is taken and every decoded byte has arrived.
    task automatic wait_until_idle();
        while (pending_requests.size() != 0 || s_tvalid || expected_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_start_position(input logic [11:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        start_pos = value;
        gen_start = value;
    endtask

    // Request driver: takes the next request from the queue when the last one went.
    always @(negedge aclk) begin
        if (!s_tvalid || in_taken) begin
            if (send_gap != 0) begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0 && send_idle_pct != 0 &&
                         $urandom_range(99, 0) < send_idle_pct) begin
                send_gap = $urandom_range(14, 0);
                s_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_requests[0].in_byte;
                s_tuser  <= pending_requests[0].new_stream;
                void'(pending_requests.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Accepted requests go straight into the model.
    always @(posedge aclk) begin
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) begin
            decode_request(s_tdata, s_tuser);
        end
    end

    // Receiver ready: one long stall once, random idle bursts otherwise.
    always @(negedge aclk) begin
        if (long_hold_go && !long_hold_used) begin
            long_hold_used = 1'b1;
            hold_left      = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap = recv_gap - 1;
            m_tready <= 1'b0;
        end else if (recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct) begin
            recv_gap = $urandom_range(14, 0);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result monitor: compare each decoded byte with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                $error("out_byte: expected nothing, actual %02h", m_tdata);
                mismatches++;
            end else begin
                if (m_tdata !== expected_bytes[0].out_byte) begin
                    $error("out_byte: expected %02h, actual %02h",
                           expected_bytes[0].out_byte, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== expected_bytes[0].last_of_run) begin
                    $error("last_of_run: expected %0b, actual %0b",
                           expected_bytes[0].last_of_run, m_tlast);
                    mismatches++;
                end
                void'(expected_bytes.pop_front());
            end
        end
    end

    // Watchdog on cycles in which no request and no result is accepted.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("lzss_stream_decoder verification failed");
        $finish;
    end

    // Sequence of phases.
    initial begin
        foreach (hist[k]) begin
            hist[k] = 8'h00;
        end
        send_idle_pct = 30;
        recv_idle_pct = 30;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed stream at the reset start position, without a new-stream mark.
        // Flags 0xD3: literal, literal, reference, reference, literal,
        // reference, literal, literal.
        push_request(8'hD3, 1'b0);
        push_request(8'h00, 1'b0);
        push_request(8'hFF, 1'b0);
        // Longest run, one byte behind the pointer, wrapping the window.
        push_request(8'hEF, 1'b0);
        push_request(8'hFF, 1'b0);
        // Shortest run from the bottom of the window.
        push_request(8'h00, 1'b0);
        push_request(8'h00, 1'b0);
        push_request(8'h5A, 1'b0);
        // Top offset of the window, already filled by the longest run.
        push_request(8'hFF, 1'b0);
        push_request(8'hF0, 1'b0);
        push_request(8'hA5, 1'b0);
        push_request(8'h80, 1'b0);
        // New stream, then a reference cut short by another new stream.
        push_request(8'h00, 1'b1);
        push_request(8'h34, 1'b0);
        push_request(8'h01, 1'b1);
        push_request(8'h7E, 1'b0);
        // New stream with every token a literal.
        push_request(8'hFF, 1'b1);
        push_request(8'h81, 1'b0);
        gen_broken = 1'b1;
        wait_until_idle();

        // Lowest start position, sender never idle, one long output stall.
        write_start_position(12'h000);
        send_idle_pct = 0;
        recv_idle_pct = 25;
        queue_random_phase(PHASE_ITEMS);
        long_hold_go = 1'b1;
        wait_until_idle();

        // Highest start position, heavy idling on both sides.
        write_start_position(12'hFFF);
        send_idle_pct = 50;
        recv_idle_pct = 50;
        queue_random_phase(PHASE_ITEMS);
        wait_until_idle();

        // Random start position, light idling on the sender only.
        write_start_position(12'($urandom_range(4095, 0)));
        send_idle_pct = 20;
        recv_idle_pct = 0;
        queue_random_phase(PHASE_ITEMS);
        wait_until_idle();

        // Final stretch at full rate.
        write_start_position(12'($urandom_range(4095, 0)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_phase(PHASE_ITEMS);
        wait_until_idle();

        if (mismatches == 0) begin
            $display("lzss_stream_decoder verification clean");
        end else begin
            $display("lzss_stream_decoder verification failed");
        end
        $finish;
    end

endmodule
